>>> src/ttb_pkg.sv
// Shared types and constants for the text terminal tile buffer.
`default_nettype none
package ttb_pkg;

  typedef enum logic [3:0] {
    CMD_PUT       = 4'd0,
    CMD_LEFT      = 4'd1,
    CMD_RIGHT     = 4'd2,
    CMD_UP        = 4'd3,
    CMD_DOWN      = 4'd4,
    CMD_BKSP      = 4'd5,
    CMD_CLEAR     = 4'd6,
    CMD_TICK      = 4'd7,
    CMD_BLINK_ON  = 4'd8,
    CMD_BLINK_OFF = 4'd9,
    CMD_READ      = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    REG_COLS_LOG2 = 3'd0,
    REG_ROWS_LOG2 = 3'd1,
    REG_CLR_FG    = 3'd2,
    REG_CLR_BG    = 3'd3,
    REG_WR_FG     = 3'd4,
    REG_WR_BG     = 3'd5,
    REG_BLINK_IVL = 3'd6
  } reg_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_LATCH, OP_EXEC, OP_SCR_RD, OP_SCR_WR, OP_BLK,
    OP_BS_RD, OP_BS_WR, OP_BS_FILL, OP_CLR, OP_TGL, OP_SAVE, OP_READ
  } op_e;

  typedef enum logic [2:0] {
    NX_DONE, NX_SCROLL, NX_BKSP, NX_CLEAR, NX_TOGGLE, NX_SAVE, NX_READ
  } nxt_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EXEC, S_SCR, S_SCR_RD, S_SCR_WR, S_BLK, S_BS,
    S_BS_RD, S_BS_WR, S_BS_FILL, S_CLR, S_TGL, S_SAVE, S_READ, S_DONE
  } state_e;

  typedef struct packed {
    op_e  op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    nxt_e nxt;
    logic scr_more;
    logic bs_more;
    logic in_range;
    logic init_last;
  } dp_stat_t;

  localparam logic [7:0] BLANK         = 8'd32;
  localparam logic [7:0] SYM_CR        = 8'd13;
  localparam logic [7:0] SYM_LF        = 8'd10;
  localparam logic [7:0] BLINK_BIT     = 8'h80;
  localparam logic [7:0] BLINK_IVL_RST = 8'd20;
  localparam logic [2:0] COLS_LOG2_RST = 3'd6;
  localparam logic [2:0] ROWS_LOG2_RST = 3'd5;

endpackage
`default_nettype wire

>>> src/ttb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ttb_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> src/ttb_ctrl.sv
// Command sequencer for the tile buffer.
`default_nettype none
module ttb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire ttb_pkg::dp_stat_t stat_i,
  output ttb_pkg::dp_cmd_t       cmd_o
);
  import ttb_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  assign load        = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_valid_d = (out_valid_q && !out_ready_i) || load;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:    if (stat_i.init_last) state_d = S_IDLE;
      S_IDLE:    if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        case (stat_i.nxt)
          NX_SCROLL: state_d = S_SCR;
          NX_BKSP:   state_d = S_BS;
          NX_CLEAR:  state_d = S_CLR;
          NX_TOGGLE: state_d = S_TGL;
          NX_SAVE:   state_d = S_SAVE;
          NX_READ:   state_d = S_READ;
          default:   state_d = S_DONE;
        endcase
      end
      S_SCR:     state_d = stat_i.scr_more ? S_SCR_RD : S_BLK;
      S_SCR_RD:  state_d = S_SCR_WR;
      S_SCR_WR:  state_d = S_SCR;
      S_BLK:     if (!stat_i.in_range) state_d = S_DONE;
      S_BS:      state_d = stat_i.bs_more ? S_BS_RD : S_BS_FILL;
      S_BS_RD:   state_d = S_BS_WR;
      S_BS_WR:   state_d = S_BS;
      S_BS_FILL: state_d = S_DONE;
      S_CLR:     if (!stat_i.in_range) state_d = S_DONE;
      S_TGL:     state_d = S_DONE;
      S_SAVE:    state_d = S_DONE;
      S_READ:    state_d = S_DONE;
      S_DONE:    if (load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load_out = load;
    case (state_q)
      S_INIT:    cmd_o.op = OP_INIT;
      S_IDLE:    cmd_o.op = in_valid_i ? OP_LATCH : OP_NONE;
      S_EXEC:    cmd_o.op = OP_EXEC;
      S_SCR_RD:  cmd_o.op = OP_SCR_RD;
      S_SCR_WR:  cmd_o.op = OP_SCR_WR;
      S_BLK:     cmd_o.op = OP_BLK;
      S_BS_RD:   cmd_o.op = OP_BS_RD;
      S_BS_WR:   cmd_o.op = OP_BS_WR;
      S_BS_FILL: cmd_o.op = OP_BS_FILL;
      S_CLR:     cmd_o.op = OP_CLR;
      S_TGL:     cmd_o.op = OP_TGL;
      S_SAVE:    cmd_o.op = OP_SAVE;
      S_READ:    cmd_o.op = OP_READ;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted transfer did not start execution");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded result not presented");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !load) |=> (state_q == S_DONE))
    else $error("result dropped while output busy");
endmodule
`default_nettype wire

>>> src/ttb_dp.sv
// Datapath: tile stores, cursor, blink state, configuration and result registers.
`default_nettype none
module ttb_dp #(
  parameter int MaxColsLog2 = 6,
  parameter int MaxRowsLog2 = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ttb_pkg::dp_cmd_t cmd_i,
  output ttb_pkg::dp_stat_t     stat_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [15:0]      cfg_data_i,
  input  wire logic [3:0]       cmd_in_i,
  input  wire logic [7:0]       symbol_i,
  input  wire logic [10:0]      tile_index_i,
  output logic      [10:0]      cursor_at_o,
  output logic      [7:0]       read_char_o,
  output logic      [15:0]      read_fg_o,
  output logic      [15:0]      read_bg_o,
  output logic                  blinking_o
);
  import ttb_pkg::*;

  localparam int AW = MaxColsLog2 + MaxRowsLog2;
  localparam int PW = AW + 1;
  localparam int Depth = 1 << AW;

  logic [2:0]  cols_log2_q, rows_log2_q;
  logic [15:0] clr_fg_q, clr_bg_q, wr_fg_q, wr_bg_q;
  logic [7:0]  ivl_q;

  logic [3:0]  cmd_q, cmd_d;
  logic [7:0]  sym_q, sym_d;
  logic [10:0] idx_q, idx_d;

  logic [AW-1:0] cursor_q, cursor_d;
  logic          blink_q, blink_d;
  logic [7:0]    cnt_q, cnt_d, saved_q, saved_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [7:0]    res_c_q, res_c_d;
  logic [15:0]   res_f_q, res_f_d, res_b_q, res_b_d;

  logic [2:0]    cl, rl;
  logic [PW-1:0] cols, tiles, cur_w, adv_sum, lf_sum;
  logic [AW-1:0] colmask, tmask, aligned;
  logic [AW+11:0] idx_w;
  logic [AW+10:0] cur_ext;
  logic          idx_ok;

  logic          we_c, we_f, we_b;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wd_c, rd_c;
  logic [15:0]   wd_f, wd_b, rd_f, rd_b;
  nxt_e          nxt;

  assign cl      = (cols_log2_q > 3'(MaxColsLog2)) ? 3'(MaxColsLog2) : cols_log2_q;
  assign rl      = (rows_log2_q > 3'(MaxRowsLog2)) ? 3'(MaxRowsLog2) : rows_log2_q;
  assign cols    = PW'(1) << cl;
  assign tiles   = PW'(1) << ({1'b0, cl} + {1'b0, rl});
  assign colmask = AW'(cols - PW'(1));
  assign tmask   = AW'(tiles - PW'(1));
  assign cur_w   = {1'b0, cursor_q};
  assign aligned = cursor_q & ~colmask;
  assign adv_sum = cur_w + ((cmd_q == CMD_DOWN) ? cols : PW'(1));
  assign lf_sum  = {1'b0, aligned} + cols;
  assign idx_w   = (AW+12)'(idx_q);
  assign idx_ok  = idx_w < (AW+12)'(tiles);
  assign cur_ext = (AW+11)'(cursor_q);

  assign stat_o.nxt       = nxt;
  assign stat_o.scr_more  = (ptr_q + cols) < tiles;
  assign stat_o.bs_more   = (ptr_q[AW-1:0] & colmask) != '0;
  assign stat_o.in_range  = ptr_q < tiles;
  assign stat_o.init_last = ptr_q[AW-1:0] == '1;

  always_comb begin
    cmd_d = cmd_q; sym_d = sym_q; idx_d = idx_q;
    cursor_d = cursor_q; blink_d = blink_q; cnt_d = cnt_q; saved_d = saved_q;
    ptr_d = ptr_q; res_c_d = res_c_q; res_f_d = res_f_q; res_b_d = res_b_q;
    we_c = 1'b0; we_f = 1'b0; we_b = 1'b0;
    waddr = ptr_q[AW-1:0]; raddr = ptr_q[AW-1:0];
    wd_c = BLANK; wd_f = rd_f; wd_b = rd_b;
    nxt = NX_DONE;
    case (cmd_i.op)
      OP_INIT: begin
        we_c = 1'b1; we_f = 1'b1; we_b = 1'b1;
        wd_f = '0; wd_b = '0;
        ptr_d = ptr_q + PW'(1);
      end
      OP_LATCH: begin
        cmd_d = cmd_in_i; sym_d = symbol_i; idx_d = tile_index_i;
        cursor_d = cursor_q & tmask;
        res_c_d = '0; res_f_d = '0; res_b_d = '0;
      end
      OP_EXEC: begin
        case (cmd_q)
          CMD_PUT: begin
            if (sym_q == SYM_CR) begin
              cursor_d = aligned;
            end else if (sym_q == SYM_LF) begin
              if (lf_sum >= tiles) begin
                cursor_d = aligned; ptr_d = '0; nxt = NX_SCROLL;
              end else begin
                cursor_d = lf_sum[AW-1:0];
              end
            end else begin
              we_c = 1'b1; we_f = 1'b1; waddr = cursor_q;
              wd_c = sym_q; wd_f = wr_fg_q;
              if (adv_sum >= tiles) begin
                cursor_d = AW'(adv_sum - cols); ptr_d = '0; nxt = NX_SCROLL;
              end else begin
                cursor_d = adv_sum[AW-1:0];
              end
            end
          end
          CMD_LEFT: if (cursor_q != '0) cursor_d = cursor_q - AW'(1);
          CMD_UP:   if (cur_w >= cols) cursor_d = AW'(cur_w - cols);
          CMD_RIGHT, CMD_DOWN: begin
            if (adv_sum >= tiles) begin
              cursor_d = AW'(adv_sum - cols); ptr_d = '0; nxt = NX_SCROLL;
            end else begin
              cursor_d = adv_sum[AW-1:0];
            end
          end
          CMD_BKSP: begin
            if (cursor_q != '0) begin
              cursor_d = cursor_q - AW'(1); ptr_d = cur_w; nxt = NX_BKSP;
            end
          end
          CMD_CLEAR: begin
            ptr_d = '0; nxt = NX_CLEAR;
          end
          CMD_TICK: begin
            if (blink_q) begin
              if (cnt_q == '0) begin
                raddr = cursor_q; nxt = NX_TOGGLE; cnt_d = ivl_q - 8'd1;
              end else begin
                cnt_d = cnt_q - 8'd1;
              end
            end
          end
          CMD_BLINK_ON: begin
            raddr = cursor_q; nxt = NX_SAVE; blink_d = 1'b1; cnt_d = '0;
          end
          CMD_BLINK_OFF: begin
            blink_d = 1'b0; we_c = 1'b1; waddr = cursor_q; wd_c = saved_q;
          end
          CMD_READ: begin
            if (idx_ok) begin
              raddr = idx_w[AW-1:0]; nxt = NX_READ;
            end
          end
          default: ;
        endcase
      end
      OP_SCR_RD: raddr = AW'(ptr_q + cols);
      OP_SCR_WR: begin
        we_c = 1'b1; we_f = 1'b1; we_b = 1'b1; wd_c = rd_c;
        ptr_d = ptr_q + PW'(1);
      end
      OP_BLK: begin
        if (stat_o.in_range) begin
          we_c = 1'b1; ptr_d = ptr_q + PW'(1);
        end
      end
      OP_BS_RD: raddr = ptr_q[AW-1:0];
      OP_BS_WR: begin
        we_c = 1'b1; we_f = 1'b1; we_b = 1'b1; wd_c = rd_c;
        waddr = AW'(ptr_q - PW'(1)); ptr_d = ptr_q + PW'(1);
      end
      OP_BS_FILL: begin
        we_c = 1'b1; we_f = 1'b1; we_b = 1'b1;
        wd_f = wr_fg_q; wd_b = wr_bg_q; waddr = AW'(ptr_q - PW'(1));
      end
      OP_CLR: begin
        if (stat_o.in_range) begin
          we_c = 1'b1; we_f = 1'b1; we_b = 1'b1;
          wd_f = clr_fg_q; wd_b = clr_bg_q; ptr_d = ptr_q + PW'(1);
        end
      end
      OP_TGL: begin
        we_c = 1'b1; waddr = cursor_q; wd_c = rd_c ^ BLINK_BIT;
      end
      OP_SAVE: saved_d = rd_c;
      OP_READ: begin
        res_c_d = rd_c; res_f_d = rd_f; res_b_d = rd_b;
      end
      default: ;
    endcase
  end

  ttb_ram #(.Width(8),  .Depth(Depth)) u_char (
    .clk_i, .we_i(we_c), .waddr_i(waddr), .wdata_i(wd_c), .raddr_i(raddr), .rdata_o(rd_c));
  ttb_ram #(.Width(16), .Depth(Depth)) u_fg (
    .clk_i, .we_i(we_f), .waddr_i(waddr), .wdata_i(wd_f), .raddr_i(raddr), .rdata_o(rd_f));
  ttb_ram #(.Width(16), .Depth(Depth)) u_bg (
    .clk_i, .we_i(we_b), .waddr_i(waddr), .wdata_i(wd_b), .raddr_i(raddr), .rdata_o(rd_b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_log2_q <= COLS_LOG2_RST;
      rows_log2_q <= ROWS_LOG2_RST;
      clr_fg_q    <= '0;
      clr_bg_q    <= '0;
      wr_fg_q     <= '0;
      wr_bg_q     <= '0;
      ivl_q       <= BLINK_IVL_RST;
      cursor_q    <= '0;
      blink_q     <= 1'b0;
      cnt_q       <= '0;
      saved_q     <= BLANK;
      ptr_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_index_i))
          REG_COLS_LOG2: cols_log2_q <= cfg_data_i[2:0];
          REG_ROWS_LOG2: rows_log2_q <= cfg_data_i[2:0];
          REG_CLR_FG:    clr_fg_q    <= cfg_data_i;
          REG_CLR_BG:    clr_bg_q    <= cfg_data_i;
          REG_WR_FG:     wr_fg_q     <= cfg_data_i;
          REG_WR_BG:     wr_bg_q     <= cfg_data_i;
          REG_BLINK_IVL: ivl_q       <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      cursor_q <= cursor_d;
      blink_q  <= blink_d;
      cnt_q    <= cnt_d;
      saved_q  <= saved_d;
      ptr_q    <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    sym_q   <= sym_d;
    idx_q   <= idx_d;
    res_c_q <= res_c_d;
    res_f_q <= res_f_d;
    res_b_q <= res_b_d;
    if (cmd_i.load_out) begin
      cursor_at_o <= cur_ext[10:0];
      read_char_o <= res_c_q;
      read_fg_o   <= res_f_q;
      read_bg_o   <= res_b_q;
      blinking_o  <= blink_q;
    end
  end

  a_bs_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_BS_WR || cmd_i.op == OP_BS_FILL) |-> (ptr_q != '0))
    else $error("backspace shift below tile zero");
  a_tgl_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_TGL) |-> $past(nxt == NX_TOGGLE))
    else $error("toggle without cursor read");
endmodule
`default_nettype wire

>>> src/text_terminal_tile_buffer.sv
// Top level of the text terminal tile buffer.
//  channel | direction | signals
//  in      | sink      | in_valid_i/in_ready_o, cmd_i, symbol_i, tile_index_i
//  out     | source    | out_valid_o/out_ready_i, cursor_at_o, read_*_o, blinking_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
// Simple commands pass through S_IDLE, S_EXEC and S_DONE; an in-range read, a toggling
// tick and blink on add S_READ, S_TGL or S_SAVE. Scroll moves each tile through S_SCR,
// S_SCR_RD and S_SCR_WR, then blanks the bottom row in S_BLK; clear writes each tile
// in S_CLR; backspace shifts each tile through S_BS, S_BS_RD and S_BS_WR, then fills
// in S_BS_FILL. Each step uses the one read port and the one write port of the stores.
// After reset a fill pass writes every store tile, with in_ready_o low. A finished
// result waits in the output register while the next transfer is accepted.
`default_nettype none
module text_terminal_tile_buffer #(
  parameter int MAX_COLUMNS_LOG2 = 6,
  parameter int MAX_ROWS_LOG2    = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [7:0]  symbol_i,
  input  wire logic [10:0] tile_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [10:0] cursor_at_o,
  output logic      [7:0]  read_char_o,
  output logic      [15:0] read_fg_o,
  output logic      [15:0] read_bg_o,
  output logic             blinking_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import ttb_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  ttb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(dp_stat), .cmd_o(dp_cmd));

  ttb_dp #(.MaxColsLog2(MAX_COLUMNS_LOG2), .MaxRowsLog2(MAX_ROWS_LOG2)) u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .stat_o(dp_stat),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .cmd_in_i(cmd_i), .symbol_i, .tile_index_i,
    .cursor_at_o, .read_char_o, .read_fg_o, .read_bg_o, .blinking_o);
endmodule
`default_nettype wire
